@@ hw/rtl/mvb_pkg.sv @@
// shared types, codes and sizes of the matrix-vector multiply with bias block
package mvb_pkg;

	// field widths
	localparam int VAL_W = 16;
	localparam int IDX_W = 4;
	localparam int OP_W  = 2;
	localparam int CFG_W = 5;
	localparam int ACC_W = 40;

	// default store sizes
	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// register reset value and indexes
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// input op codes
	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_ELEM   = 2'd2;

	// command kinds held in the queue
	typedef enum logic [1:0] {
		CMD_WEIGHT,
		CMD_BIAS,
		CMD_ELEM
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [VAL_W-1:0]  value;
		logic                     last;
	} cmd_t;

endpackage

@@ hw/rtl/mvb_if.sv @@
// item and result channels of the matrix-vector multiply with bias block
interface mvb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [3:0]         row_index;
	logic [3:0]         col_index;
	logic signed [15:0] value;

	modport source (output valid, output op, output row_index, output col_index,
		output value, input ready);
	modport sink (input valid, input op, input row_index, input col_index,
		input value, output ready);
endinterface

interface mvb_result_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_row;
	logic signed [15:0] out_value;
	logic               out_last;

	modport source (output valid, output out_row, output out_value, output out_last,
		input ready);
	modport sink (input valid, input out_row, input out_value, input out_last,
		output ready);
endinterface

@@ hw/rtl/matrix_vector_multiply_bias_unit.sv @@
// top level of the matrix-vector multiply with bias block
// weight and bias items pass through the command queue and are written to their store when the back end is idle
// a vector element is processed by one shared 16x16 multiplier that steps through the rows in use
// the element at the last column then emits one result per row in use, one result per cycle when taken
// the command queue takes new items, until it is full, while the back end works or a result waits
// reset is asynchronous: config to 16 rows and columns, accumulator valid bits clear, stores undefined
module matrix_vector_multiply_bias_unit #(
	parameter int MAX_ROWS = mvb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mvb_pkg::MAX_COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [mvb_pkg::CFG_W-1:0] cfg_data,
	mvb_item_if.sink                  items,
	mvb_result_if.source              results
);

	logic [mvb_pkg::CFG_W-1:0] rows_q;
	logic [mvb_pkg::CFG_W-1:0] cols_q;
	logic [mvb_pkg::CFG_W-1:0] nrows;
	logic [mvb_pkg::CFG_W-1:0] ncols;

	logic          push;
	mvb_pkg::cmd_t push_cmd;
	logic          q_full;
	logic          pop;
	logic          pop_valid;
	mvb_pkg::cmd_t pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mvb_pkg::CFG_RESET;
			cols_q <= mvb_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mvb_pkg::REG_ROWS: rows_q <= cfg_data;
				mvb_pkg::REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counts clamped to one and to the store size
	always_comb begin
		if (rows_q == '0) begin
			nrows = 5'd1;
		end else if (32'(rows_q) > MAX_ROWS) begin
			nrows = 5'(MAX_ROWS);
		end else begin
			nrows = rows_q;
		end
		if (cols_q == '0) begin
			ncols = 5'd1;
		end else if (32'(cols_q) > MAX_COLS) begin
			ncols = 5'(MAX_COLS);
		end else begin
			ncols = cols_q;
		end
	end

	mvb_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.items   (items),
		.ncols   (ncols),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	mvb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd)
	);

	mvb_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nrows    (nrows),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd),
		.pop      (pop),
		.results  (results)
	);

`ifndef ASSERT_OFF
	// a queued vector element always lies inside the columns in use
	a_elem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_cmd.kind == mvb_pkg::CMD_ELEM) |-> 5'(push_cmd.col) < ncols)
		else $error("vector element queued outside the columns in use");

	// only a vector element can end a vector
	a_last_is_elem: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cmd.last |-> push_cmd.kind == mvb_pkg::CMD_ELEM)
		else $error("vector end mark on a store write");

	// a queued item is visible to the back end in the next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> pop_valid)
		else $error("queued item lost");
`endif

endmodule

@@ hw/rtl/mvb_front.sv @@
// front end: accepts items, drops the ones with no effect, tags the vector end
module mvb_front #(
	parameter int MAX_ROWS = mvb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mvb_pkg::MAX_COLS_DEF
) (
	mvb_item_if.sink                  items,
	input  logic [mvb_pkg::CFG_W-1:0] ncols,
	input  logic                      q_full,
	output logic                      push,
	output mvb_pkg::cmd_t             push_cmd
);

	logic keep;

	assign items.ready = !q_full;

	// classify the item by op and range
	always_comb begin
		keep           = 1'b0;
		push_cmd.kind  = mvb_pkg::CMD_ELEM;
		push_cmd.row   = items.row_index;
		push_cmd.col   = items.col_index;
		push_cmd.value = items.value;
		push_cmd.last  = 1'b0;
		case (items.op)
			mvb_pkg::OP_WEIGHT: begin
				push_cmd.kind = mvb_pkg::CMD_WEIGHT;
				keep = (32'(items.row_index) < MAX_ROWS) && (32'(items.col_index) < MAX_COLS);
			end
			mvb_pkg::OP_BIAS: begin
				push_cmd.kind = mvb_pkg::CMD_BIAS;
				keep = 32'(items.row_index) < MAX_ROWS;
			end
			mvb_pkg::OP_ELEM: begin
				push_cmd.kind = mvb_pkg::CMD_ELEM;
				keep = 5'(items.col_index) < ncols;
				push_cmd.last = 5'(items.col_index) == (ncols - 5'd1);
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = items.valid && items.ready && keep;

endmodule

@@ hw/rtl/mvb_queue.sv @@
// short command queue between front and back
module mvb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output mvb_pkg::cmd_t pop_cmd
);

	localparam int Depth = mvb_pkg::QUEUE_DEPTH;
	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	mvb_pkg::cmd_t   slot_q [Depth];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == CW'(Depth);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = slot_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (32'(wptr_q) == Depth - 1) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (32'(rptr_q) == Depth - 1) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/mvb_back.sv @@
// back end: stores, shared multiply-accumulate over rows, result emission
module mvb_back #(
	parameter int MAX_ROWS = mvb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mvb_pkg::MAX_COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mvb_pkg::CFG_W-1:0] nrows,
	input  logic                      pop_valid,
	input  mvb_pkg::cmd_t             pop_cmd,
	output logic                      pop,
	mvb_result_if.source              results
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WD = MAX_ROWS * MAX_COLS;
	localparam int AW = (WD > 1) ? $clog2(WD) : 1;
	localparam int AccW = mvb_pkg::ACC_W;
	localparam int VW = mvb_pkg::VAL_W;
	localparam int PrW = 2 * VW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [RW-1:0]          row_q;
	logic [AW-1:0]          waddr_q;
	logic signed [VW-1:0]   x_q;
	logic                   last_q;

	logic                   res_valid_q;
	logic [3:0]             res_row_q;
	logic signed [VW-1:0]   res_value_q;
	logic                   res_last_q;

	// stores
	logic signed [VW-1:0]   wmem [WD];
	logic signed [VW-1:0]   bmem [MAX_ROWS];
	logic [AccW-1:0]        amem [MAX_ROWS];
	logic signed [VW-1:0]   w_rd_q;
	logic signed [VW-1:0]   b_rd_q;
	logic [AccW-1:0]        a_rd_q;
	logic                   av_rd_q;
	logic [MAX_ROWS-1:0]    acc_vld_q;

	// multiply-accumulate pipeline
	logic                   v_s1;
	logic [RW-1:0]          row_s1;
	logic                   v_s2;
	logic [RW-1:0]          row_s2;
	logic signed [PrW-1:0]  prod_s2;

	logic                   row_last;
	logic                   out_free;
	logic                   w_we;
	logic [AW-1:0]          w_waddr;
	logic                   w_re;
	logic                   b_we;
	logic [RW-1:0]          b_waddr;
	logic                   drain_done;
	logic                   emit_go;
	logic                   emit_next;
	logic                   a_re;
	logic                   b_re;
	logic [RW-1:0]          rd_addr;
	logic                   a_we;
	logic [AccW-1:0]        a_wdata;
	logic                   acc_clr;
	logic [AccW-1:0]        a_eff;
	logic signed [AccW:0]   sum;
	logic                   sat_hi;
	logic                   sat_lo;
	logic signed [VW-1:0]   q88;

	assign pop        = (state_q == ST_IDLE) && pop_valid;
	assign row_last   = 32'(row_q) == (32'(nrows) - 32'd1);
	assign out_free   = !res_valid_q || results.ready;
	assign w_we       = pop && (pop_cmd.kind == mvb_pkg::CMD_WEIGHT);
	assign w_waddr    = AW'(32'(pop_cmd.row) * MAX_COLS + 32'(pop_cmd.col));
	assign b_we       = pop && (pop_cmd.kind == mvb_pkg::CMD_BIAS);
	assign b_waddr    = RW'(pop_cmd.row);
	assign w_re       = state_q == ST_MAC;
	assign drain_done = (state_q == ST_DRAIN) && !v_s1 && !v_s2;
	assign emit_go    = (state_q == ST_EMIT) && out_free;
	assign emit_next  = emit_go && !row_last;
	assign acc_clr    = emit_go && row_last;

	// accumulator and bias read port: first row, next row, or for the accumulator alone the row in stage 1
	always_comb begin
		a_re    = 1'b0;
		b_re    = 1'b0;
		rd_addr = row_s1;
		if (drain_done && last_q) begin
			a_re    = 1'b1;
			b_re    = 1'b1;
			rd_addr = '0;
		end else if (emit_next) begin
			a_re    = 1'b1;
			b_re    = 1'b1;
			rd_addr = row_q + RW'(1);
		end else if (v_s1) begin
			a_re    = 1'b1;
		end
	end

	// accumulate in stage 2; a row not yet written this vector reads as zero
	assign a_we    = v_s2;
	assign a_wdata = (av_rd_q ? a_rd_q : '0) + {{(AccW - PrW){prod_s2[PrW-1]}}, prod_s2};

	// accumulator plus aligned bias, round half up, saturate to q8.8
	assign a_eff  = av_rd_q ? a_rd_q : '0;
	assign sum    = $signed({a_eff[AccW-1], a_eff})
		+ $signed({{(AccW + 1 - VW - 8){b_rd_q[VW-1]}}, b_rd_q, 8'd0})
		+ $signed((AccW + 1)'(128));
	assign sat_hi = !sum[AccW] && (sum[AccW-1:23] != '0);
	assign sat_lo = sum[AccW] && (sum[AccW-1:23] != '1);
	always_comb begin
		if (sat_hi) begin
			q88 = 16'sh7FFF;
		end else if (sat_lo) begin
			q88 = 16'sh8000;
		end else begin
			q88 = sum[23:8];
		end
	end

	// weight store
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= pop_cmd.value;
		end
		if (w_re) begin
			w_rd_q <= wmem[waddr_q];
		end
	end

	// bias store
	always_ff @(posedge clk) begin
		if (b_we) begin
			bmem[b_waddr] <= pop_cmd.value;
		end
		if (b_re) begin
			b_rd_q <= bmem[rd_addr];
		end
	end

	// accumulator store
	always_ff @(posedge clk) begin
		if (a_we) begin
			amem[row_s2] <= a_wdata;
		end
		if (a_re) begin
			a_rd_q  <= amem[rd_addr];
			av_rd_q <= acc_vld_q[rd_addr];
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= w_rd_q * x_q;
		row_s1  <= row_q;
		row_s2  <= row_s1;
	end

	// pipeline valids and accumulator valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			acc_vld_q <= '0;
		end else begin
			v_s1 <= w_re;
			v_s2 <= v_s1;
			if (a_we) begin
				acc_vld_q[row_s2] <= 1'b1;
			end else if (acc_clr) begin
				acc_vld_q <= '0;
			end
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			waddr_q     <= '0;
			x_q         <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_row_q   <= '0;
			res_value_q <= '0;
			res_last_q  <= 1'b0;
		end else begin
			// result valid: set on emit, cleared once taken
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (pop_cmd.kind == mvb_pkg::CMD_ELEM)) begin
						x_q     <= pop_cmd.value;
						last_q  <= pop_cmd.last;
						row_q   <= '0;
						waddr_q <= AW'(pop_cmd.col);
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					row_q   <= row_q + RW'(1);
					waddr_q <= waddr_q + AW'(MAX_COLS);
					if (row_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						row_q   <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						res_row_q   <= 4'(row_q);
						res_value_q <= q88;
						res_last_q  <= row_last;
						if (row_last) begin
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + RW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid     = res_valid_q;
	assign results.out_row   = res_row_q;
	assign results.out_value = res_value_q;
	assign results.out_last  = res_last_q;

endmodule
